// ===== design/lz77_bitpacked_decompressor_top_macros.svh =====
// Assertion macros for the LZ77 bit-packed decompressor checker.
`ifndef LZ77_BITPACKED_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ77_BITPACKED_DECOMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define LZBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define LZBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lzbd_pkg.sv =====
// Shared constants and types of the LZ77 bit-packed decompressor.
package lzbd_pkg;

  localparam int HISTORY_BITS = 15;

  localparam logic [3:0] OFFSET_BITS_RESET = 4'd15;
  localparam logic [8:0] LEN_BIAS          = 9'd3;
  localparam int         DIST_BIAS         = 1;
  localparam logic [3:0] LANES             = 4'd8;
  localparam logic [4:0] LIT_TOKEN_BITS    = 5'd9;

  typedef struct packed {
    logic        hit;       // a full token was parsed
    logic        is_match;  // flag bit of the token
    logic [7:0]  lo8;       // literal byte or length code
    logic [14:0] code;      // offset code of a match
    logic        eos;       // item closed the stream
  } token_t;

endpackage

// ===== design/lzbd_ifs.sv =====
// Handshake channels of the decompressor: compressed bytes in, decoded words out.
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        bad_offset;

  modport source (output valid, output data_word, output byte_count,
                  output last_of_run, output bad_offset, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input last_of_run, input bad_offset, output ready);
endinterface

// ===== design/lzbd_unpack.sv =====
// Bit gatherer and token parser: one compressed byte per accepted item.
module lzbd_unpack (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                eos,
  input  logic [3:0]          ob,
  output lzbd_pkg::token_t    tok
);

  logic [31:0] bit_store;
  logic [5:0]  bits_held;

  logic [39:0] store;
  logic [6:0]  sum;
  logic [5:0]  held;
  logic        flag;
  logic [4:0]  need;
  logic        hit;
  logic [5:0]  rest;
  logic [39:0] shifted;
  logic [23:0] bmask;
  logic [23:0] body;
  logic [39:0] keepmask;

  assign store    = {bit_store, in_byte};
  assign sum      = {1'b0, bits_held} + 7'd8;
  assign held     = (sum > 7'd32) ? 6'd32 : sum[5:0];
  assign flag     = store[held - 6'd1];
  assign need     = flag ? (lzbd_pkg::LIT_TOKEN_BITS + {1'b0, ob})
                         : lzbd_pkg::LIT_TOKEN_BITS;
  assign hit      = held >= {1'b0, need};
  assign rest     = held - {1'b0, need};
  assign shifted  = store >> rest;
  assign bmask    = (24'd1 << (need - 5'd1)) - 24'd1;
  assign body     = shifted[23:0] & bmask;
  assign keepmask = (40'd1 << rest) - 40'd1;

  assign tok.hit      = hit;
  assign tok.is_match = flag;
  assign tok.lo8      = body[7:0];
  assign tok.code     = body[22:8];
  assign tok.eos      = eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store <= '0;
      bits_held <= '0;
    end else if (accept) begin
      if (eos) begin
        bit_store <= '0;
        bits_held <= '0;
      end else if (hit) begin
        bit_store <= 32'(store & keepmask);
        bits_held <= rest;
      end else begin
        bit_store <= store[31:0];
        bits_held <= held;
      end
    end
  end

endmodule

// ===== design/lzbd_history.sv =====
// History window RAM: one write and one registered read port, write-first.
module lzbd_history #(
  parameter int AW = lzbd_pkg::HISTORY_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // distance-one copies read the byte being written this cycle
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

// ===== design/lzbd_engine.sv =====
// Token executor: literal writes, match copies through the history RAM, word packing.
module lzbd_engine #(
  parameter int HB = lzbd_pkg::HISTORY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lzbd_pkg::token_t tok,
  output logic             idle,
  output logic             ram_we,
  output logic [HB-1:0]    ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic             ram_re,
  output logic [HB-1:0]    ram_raddr,
  input  logic [7:0]       ram_rdata,
  lzbd_out_if.source       decoded
);

  localparam int DW = HB + 1;
  localparam logic [DW-1:0] WIN = DW'(1) << HB;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_ERR  = 2'd2;
  localparam logic [1:0] S_COPY = 2'd3;

  logic [1:0]    state;
  logic [7:0]    lit;
  logic [8:0]    len_left;
  logic [8:0]    rd_left;
  logic [HB-1:0] src;
  logic [HB-1:0] wp;
  logic [DW-1:0] bd;
  logic          pending;
  logic [2:0]    lane;
  logic [63:0]   word;
  logic          eos_pend;

  logic          ov;
  logic [63:0]   od;
  logic [3:0]    oc;
  logic          ol;
  logic          obad;

  logic          free;
  logic          word_done;
  logic          consume;
  logic [63:0]   new_word;
  logic [DW-1:0] match_dist;
  logic [8:0]    len;

  assign free       = !ov || decoded.ready;
  assign word_done  = (lane == 3'd7) || (len_left == 9'd1);
  assign consume    = (state == S_COPY) && pending && (!word_done || free);
  assign new_word   = word | ({ram_rdata, 56'd0} >> {lane, 3'b000});
  assign match_dist = DW'(tok.code) + DW'(lzbd_pkg::DIST_BIAS);
  assign len        = {1'b0, tok.lo8} + lzbd_pkg::LEN_BIAS;

  assign idle      = (state == S_IDLE);
  assign ram_we    = ((state == S_LIT) && free) || consume;
  assign ram_waddr = wp;
  assign ram_wdata = (state == S_LIT) ? lit : ram_rdata;
  assign ram_re    = (state == S_COPY) && (rd_left != 9'd0) && (!pending || consume);
  assign ram_raddr = src;

  assign decoded.valid       = ov;
  assign decoded.data_word   = od;
  assign decoded.byte_count  = oc;
  assign decoded.last_of_run = ol;
  assign decoded.bad_offset  = obad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      bd      <= '0;
      pending <= 1'b0;
      ov      <= 1'b0;
    end else begin
      if (decoded.ready) begin
        ov <= 1'b0;
      end
      if (ram_we) begin
        wp <= wp + HB'(1);
        if (bd != WIN) begin
          bd <= bd + DW'(1);
        end
      end
      if (ram_re) begin
        src     <= src + HB'(1);
        rd_left <= rd_left - 9'd1;
        pending <= 1'b1;
      end else if (consume) begin
        pending <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            eos_pend <= tok.eos;
            lit      <= tok.lo8;
            if (!tok.hit) begin
              if (tok.eos) begin
                wp <= '0;
                bd <= '0;
              end
            end else if (!tok.is_match) begin
              state <= S_LIT;
            end else if (match_dist > bd) begin
              state <= S_ERR;
            end else begin
              state    <= S_COPY;
              src      <= wp - match_dist[HB-1:0];
              rd_left  <= len;
              len_left <= len;
              lane     <= '0;
              word     <= '0;
            end
          end
        end
        S_LIT: begin
          if (free) begin
            ov    <= 1'b1;
            od    <= {lit, 56'd0};
            oc    <= 4'd1;
            ol    <= 1'b1;
            obad  <= 1'b0;
            state <= S_IDLE;
            if (eos_pend) begin
              wp <= '0;
              bd <= '0;
            end
          end
        end
        S_ERR: begin
          if (free) begin
            ov    <= 1'b1;
            od    <= '0;
            oc    <= 4'd0;
            ol    <= 1'b1;
            obad  <= 1'b1;
            state <= S_IDLE;
            if (eos_pend) begin
              wp <= '0;
              bd <= '0;
            end
          end
        end
        S_COPY: begin
          if (consume) begin
            len_left <= len_left - 9'd1;
            if (word_done) begin
              ov   <= 1'b1;
              od   <= new_word;
              oc   <= {1'b0, lane} + 4'd1;
              ol   <= (len_left == 9'd1);
              obad <= 1'b0;
              lane <= '0;
              word <= '0;
            end else begin
              lane <= lane + 3'd1;
              word <= new_word;
            end
            if (len_left == 9'd1) begin
              state <= S_IDLE;
              if (eos_pend) begin
                wp <= '0;
                bd <= '0;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== design/lz77_bitpacked_decompressor_top.sv =====
// Top level of the LZ77 bit-packed decompressor.
// Takes one compressed byte per item and returns decoded bytes in words of up to
// eight lanes, first byte in the top lane. An item that completes no token leaves
// the engine idle. A literal token then writes the history RAM and loads the output
// register; a bad-offset token only loads the output register. A match copy
// streams one byte per cycle through the single read port of the history RAM, one
// read in flight, with a stall whenever a word is complete and the previous word
// has not been taken. The history RAM
// (2**HISTORY_BITS bytes) has no clearing pass; distances are checked against the
// count of bytes produced, so unwritten entries are never read. end_of_stream
// resets the bit store, write pointer and byte count after its token completes.
module lz77_bitpacked_decompressor_top #(
  parameter int HISTORY_BITS = lzbd_pkg::HISTORY_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [3:0] cfg_wdata,
  lzbd_in_if.sink    stream,
  lzbd_out_if.source decoded
);

  logic [3:0]             offset_bits;
  logic [3:0]             ob;
  logic                   accept;
  logic                   idle;
  lzbd_pkg::token_t       tok;

  logic                    ram_we;
  logic [HISTORY_BITS-1:0] ram_waddr;
  logic [7:0]              ram_wdata;
  logic                    ram_re;
  logic [HISTORY_BITS-1:0] ram_raddr;
  logic [7:0]              ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= lzbd_pkg::OFFSET_BITS_RESET;
    end else if (cfg_wen) begin
      offset_bits <= cfg_wdata;
    end
  end

  assign ob = (32'(offset_bits) > HISTORY_BITS) ? 4'(HISTORY_BITS) : offset_bits;

  assign stream.ready = idle;
  assign accept       = stream.valid && idle;

  lzbd_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (stream.in_byte),
    .eos     (stream.end_of_stream),
    .ob      (ob),
    .tok     (tok)
  );

  lzbd_history #(
    .AW (HISTORY_BITS)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lzbd_engine #(
    .HB (HISTORY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .tok       (tok),
    .idle      (idle),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .decoded   (decoded)
  );

endmodule

// ===== design/lzbd_checker.sv =====
// Port-level assertions on the decoded-word channel, bound to the top level.
`include "lz77_bitpacked_decompressor_top_macros.svh"

module lzbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] data_word,
  input logic [3:0]  byte_count,
  input logic        last_of_run,
  input logic        bad_offset
);

  `LZBD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(data_word) && $stable(byte_count) && $stable(last_of_run) && $stable(bad_offset), "stalled item changed")
  `LZBD_ASSERT_SAME(a_err_item, out_valid && bad_offset, byte_count == 4'd0 && last_of_run && data_word == 64'd0, "malformed error item")
  `LZBD_ASSERT_SAME(a_count_range, out_valid && !bad_offset, byte_count != 4'd0 && byte_count <= lzbd_pkg::LANES, "byte count out of range")
  `LZBD_ASSERT_SAME(a_full_word, out_valid && !last_of_run, byte_count == lzbd_pkg::LANES && !bad_offset, "partial word before end of run")

endmodule

bind lz77_bitpacked_decompressor_top lzbd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (decoded.valid),
  .out_ready   (decoded.ready),
  .data_word   (decoded.data_word),
  .byte_count  (decoded.byte_count),
  .last_of_run (decoded.last_of_run),
  .bad_offset  (decoded.bad_offset)
);

// ===== verif/lz77_bitpacked_decompressor_top_tb.sv =====
// Self-checking testbench of the LZ77 bit-packed decompressor: token streams in, decoded words checked.

localparam int WIN_BYTES = 1 << lzbd_pkg::HISTORY_BITS;

typedef struct packed {
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        bad_offset;
} decoded_word_t;

typedef enum int {TAKE_ALL, TAKE_MOST, TAKE_FEW, TAKE_PERIODIC} take_mode_t;

class lz_decode_checker;
  decoded_word_t pending_words[$];
  logic [7:0]    window [WIN_BYTES];
  logic [31:0]   bit_store;
  int            bits_held;
  int            offset_width;
  int            wr_ptr;
  int            produced;
  int            mismatches;

  function new();
    offset_width = int'(lzbd_pkg::OFFSET_BITS_RESET);
    bit_store    = '0;
    bits_held    = 0;
    wr_ptr       = 0;
    produced     = 0;
    mismatches   = 0;
    for (int i = 0; i < WIN_BYTES; i++) window[i] = '0;
  endfunction

  function void set_width(logic [3:0] v);
    offset_width = int'(v);
  endfunction

  function int pending_count();
    return pending_words.size();
  endfunction

  function void keep_byte(logic [7:0] b);
    window[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % WIN_BYTES;
    if (produced < WIN_BYTES) produced++;
  endfunction

  function void add_word(logic [63:0] w, int cnt, logic l, logic bad);
    decoded_word_t r;
    r.data_word   = w;
    r.byte_count  = cnt[3:0];
    r.last_of_run = l;
    r.bad_offset  = bad;
    pending_words.push_back(r);
  endfunction

  // parse at most one token per compressed byte
  function void note_byte(logic [7:0] b, logic eos);
    logic [63:0] store;
    logic [63:0] body;
    logic [63:0] word;
    logic        flag;
    int          held, w, need, rest, len, span, src, lane;
    store = ({32'd0, bit_store} << 8) | {56'd0, b};
    held  = bits_held + 8;
    if (held > 32) held = 32;
    w = (offset_width > lzbd_pkg::HISTORY_BITS) ? lzbd_pkg::HISTORY_BITS : offset_width;
    flag = store[held-1];
    need = flag ? 9 + w : 9;
    if (held >= need) begin
      rest  = held - need;
      body  = (store >> rest) & ((64'd1 << (need - 1)) - 64'd1);
      held  = rest;
      store = store & ((64'd1 << rest) - 64'd1);
      if (!flag) begin
        keep_byte(body[7:0]);
        add_word({body[7:0], 56'd0}, 1, 1'b1, 1'b0);
      end else begin
        len  = int'(body[7:0]) + int'(lzbd_pkg::LEN_BIAS);
        span = int'(body >> 8) + lzbd_pkg::DIST_BIAS;
        if (span > produced) begin
          add_word(64'd0, 0, 1'b1, 1'b1);
        end else begin
          src  = (wr_ptr - span + WIN_BYTES) % WIN_BYTES;
          word = '0;
          lane = 0;
          for (int k = 0; k < len; k++) begin
            b = window[src];
            src = (src + 1) % WIN_BYTES;
            keep_byte(b);
            word = word | ({56'd0, b} << (56 - 8 * lane));
            lane++;
            if (lane == int'(lzbd_pkg::LANES) || k + 1 == len) begin
              add_word(word, lane, k + 1 == len, 1'b0);
              word = '0;
              lane = 0;
            end
          end
        end
      end
    end
    if (eos) begin
      bit_store = '0;
      bits_held = 0;
      wr_ptr    = 0;
      produced  = 0;
    end else begin
      bit_store = store[31:0];
      bits_held = held;
    end
  endfunction

  function void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_word(logic [63:0] w, logic [3:0] cnt, logic l, logic bad);
    decoded_word_t want;
    if (pending_words.size() == 0) begin
      flag_error($sformatf("unexpected word %h count %0d last %b bad %b", w, cnt, l, bad));
      return;
    end
    want = pending_words.pop_front();
    if (want.data_word !== w || want.byte_count !== cnt || want.last_of_run !== l ||
        want.bad_offset !== bad)
      flag_error($sformatf("expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                           want.data_word, want.byte_count, want.last_of_run,
                           want.bad_offset, w, cnt, l, bad));
  endfunction
endclass

module lz77_bitpacked_decompressor_top_tb;
  localparam int QUIET_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       cfg_wen;
  logic [3:0] cfg_wdata;

  lzbd_in_if  stream_ch();
  lzbd_out_if decoded_ch();

  lz77_bitpacked_decompressor_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .stream(stream_ch),
    .decoded(decoded_ch)
  );

  lz_decode_checker decode_check;

  bit         token_bits[$];
  int         code_width;
  int         stream_out;
  int         items_sent = 0;
  int         burst_left;
  bit         valid_up = 1'b0;
  int         quiet = 0;
  take_mode_t take_mode = TAKE_ALL;
  int         mode_left = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wen) decode_check.set_width(cfg_wdata);
      if (stream_ch.valid && stream_ch.ready)
        decode_check.note_byte(stream_ch.in_byte, stream_ch.end_of_stream);
      if (decoded_ch.valid && decoded_ch.ready)
        decode_check.check_word(decoded_ch.data_word, decoded_ch.byte_count,
                                decoded_ch.last_of_run, decoded_ch.bad_offset);
    end
  end

  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (decoded_ch.valid && decoded_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      take_mode = take_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 200);
    end else begin
      mode_left--;
    end
    case (take_mode)
      TAKE_ALL:  decoded_ch.ready <= 1'b1;
      TAKE_MOST: decoded_ch.ready <= ($urandom_range(0, 3) != 0);
      TAKE_FEW:  decoded_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   decoded_ch.ready <= (mode_left % 4 == 0);
    endcase
  end

  function int pick_burst();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 8);
  endfunction

  function int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 12);
    if (r < 19) return $urandom_range(13, 60);
    return $urandom_range(200, 255);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    stream_ch.valid         <= 1'b1;
    stream_ch.in_byte       <= b;
    stream_ch.end_of_stream <= eos;
    valid_up = 1'b1;
    do @(posedge clk); while (!stream_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      stream_ch.valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  task automatic put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) token_bits.push_back(v[i]);
  endtask

  task automatic emit_literal(input logic [7:0] b);
    put_bits(32'd0, 1);
    put_bits({24'd0, b}, 8);
    stream_out++;
  endtask

  task automatic emit_match(input int code, input int lcode);
    put_bits(32'd1, 1);
    put_bits(code, code_width);
    put_bits(lcode, 8);
    if (code + 1 <= stream_out) stream_out += lcode + 3;
  endtask

  // pad to a byte boundary, ship the bytes, mark the last one
  task automatic send_stream();
    logic [7:0] b;
    int         nbytes;
    while (token_bits.size() % 8 != 0) token_bits.push_back($urandom_range(0, 1));
    nbytes = token_bits.size() / 8;
    for (int i = 0; i < nbytes; i++) begin
      for (int j = 0; j < 8; j++) b = {b[6:0], token_bits.pop_front()};
      send_byte(b, i == nbytes - 1);
    end
    stream_out = 0;
  endtask

  task automatic random_stream();
    int tokens, choice, limit, span;
    tokens = $urandom_range(1, 14);
    for (int t = 0; t < tokens; t++) begin
      choice = $urandom_range(0, 99);
      limit  = 1 << code_width;
      if (choice >= 90 && stream_out < limit) begin
        emit_match($urandom_range(stream_out, limit - 1), pick_length());
      end else if (stream_out == 0 || choice < 40) begin
        emit_literal(8'($urandom_range(0, 255)));
      end else begin
        span = (stream_out < limit) ? stream_out : limit;
        if (choice >= 50) span = $urandom_range(1, span);
        emit_match(span - 1, pick_length());
      end
    end
    // truncated token before end of stream
    if ($urandom_range(0, 7) == 0) put_bits($urandom, $urandom_range(1, 8 + code_width));
    send_stream();
  endtask

  task automatic noise_stream();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  task automatic park_sender();
    if (valid_up) begin
      stream_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (decode_check.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_width(input int v);
    park_sender();
    wait_drained();
    repeat (12) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v[3:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    code_width = v;
  endtask

  task automatic random_phase(input int w, input int target);
    int start;
    write_width(w);
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 6) == 0) noise_stream();
      else random_stream();
    end
  endtask

  initial begin
    decode_check = new();
    rst                     <= 1'b1;
    cfg_wen                 <= 1'b0;
    cfg_wdata               <= '0;
    stream_ch.valid         <= 1'b0;
    stream_ch.in_byte       <= '0;
    stream_ch.end_of_stream <= 1'b0;
    code_width = int'(lzbd_pkg::OFFSET_BITS_RESET);
    stream_out = 0;
    burst_left = pick_burst();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // literal extremes, overlapping copy, longest copy, far bad distance
    emit_literal(8'h00);
    emit_literal(8'hFF);
    emit_match(0, 0);
    emit_match(1, 255);
    emit_match(15'h7FFF, 0);
    send_stream();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // empty offset code: bad at stream start, then distance one
    write_width(0);
    emit_match(0, 0);
    emit_literal(8'h5A);
    emit_match(0, 7);
    send_stream();

    random_phase(15, 46);
    random_phase(1, 46);
    random_phase(0, 46);
    random_phase(8, 46);
    random_phase(3, 46);
    random_phase(12, 46);
    random_phase(15, 46);

    park_sender();
    wait_drained();
    repeat (20) @(posedge clk);
    if (decode_check.mismatches == 0 && decode_check.pending_count() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
